// ===== rtl/lspg_pkg.sv =====
// Shared constants and types for the LED strip pattern generator.
package lspg_pkg;

    localparam int LED_COUNT_DEF = 32;
    localparam int FRAC_W        = 16;
    localparam int NOW_W         = 32;
    localparam int RATE_W        = 24;
    localparam int PROD_W        = RATE_W + NOW_W;
    localparam int NUM_W         = PROD_W - FRAC_W;
    localparam int MOD_W         = 7;
    localparam int REM_W         = 6;
    localparam int POS_W         = 22;
    localparam int JPOS_W        = 17;
    localparam int JIT_MOD       = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int RGB_W         = 24;

    localparam logic [1:0] MODE_SOLID  = 2'd0;
    localparam logic [1:0] MODE_SWEEP  = 2'd1;
    localparam logic [1:0] MODE_JITTER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_MOD   = 5'b00100,
        S_UPD   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef enum logic [4:0] {
        RP_IDLE   = 5'b00001,
        RP_FOLD_A = 5'b00010,
        RP_FOLD_B = 5'b00100,
        RP_RECIP  = 5'b01000,
        RP_FIX    = 5'b10000
    } t_red_phase;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
    } t_red_req;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } t_red_rsp;

endpackage

// ===== rtl/led_strip_pattern_generator_core.sv =====
// Top level of the LED strip pattern generator: config, position update and LED beat output.
//
// Each accepted frame request yields LED_COUNT output beats, index 0 first, frame_end on the
// last. Solid mode streams its beats straight away after the idle state that takes the
// request. Sweep and jitter modes first advance their position: the idle state takes the
// request, then come the 24x32 speed-times-elapsed multiply, the remainder unit (two folds, a
// reciprocal multiply and a correction), a wait to see it finish and the update state, then
// the LED beats. A new request is taken once the last beat of a frame sits in the output
// register; output stalls stretch the beat phase cycle for cycle.
module led_strip_pattern_generator_core import lspg_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [NOW_W-1:0]      i_now_ms,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [5:0]            o_led_index,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic                  o_frame_end
);

    localparam int              SWEEP_RANGE_I = LED_COUNT * (2 ** FRAC_W);
    localparam int              JIT_RANGE_I   = JIT_MOD * (2 ** FRAC_W);
    localparam logic [23:0]     SWEEP_RANGE   = 24'(SWEEP_RANGE_I);
    localparam logic [23:0]     JIT_RANGE     = 24'(JIT_RANGE_I);
    localparam logic [5:0]      LAST_LED      = 6'(LED_COUNT - 1);
    localparam logic [6:0]      COUNT_7       = 7'(LED_COUNT);

    // config
    logic [1:0]        r_mode;
    logic [RGB_W-1:0]  r_solid, r_fore, r_back;
    logic [7:0]        r_block;
    logic [RATE_W-1:0] r_rate;

    // state
    t_state            r_state, n_state;
    logic [NOW_W-1:0]  r_prior, n_prior;
    logic [POS_W-1:0]  r_sweep_pos, n_sweep_pos;
    logic [JPOS_W-1:0] r_jit_pos, n_jit_pos;
    logic [NOW_W-1:0]  r_now, n_now;
    logic [NOW_W-1:0]  r_elapsed, n_elapsed;
    logic [RATE_W-1:0] r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [5:0]        r_led, n_led;
    logic [7:0]        r_bcnt, n_bcnt;
    logic              r_qpar, n_qpar;

    // output register
    logic              r_o_valid, n_o_valid;
    logic [5:0]        r_o_idx, n_o_idx;
    logic [RGB_W-1:0]  r_o_rgb, n_o_rgb;
    logic              r_o_end, n_o_end;

    t_red_req          w_req;
    t_red_rsp          w_rsp;

    logic              w_sweep, w_jit, w_accept, w_load, w_last;
    logic [23:0]       w_range, w_pos, w_step, w_sum, w_new;
    logic [6:0]        w_diff, w_off;
    logic [8:0]        w_bnext;
    logic              w_fg;
    logic [RGB_W-1:0]  w_rgb;

    lspg_modred #(
        .MODULUS (LED_COUNT)
    ) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_sweep  = (r_mode == MODE_SWEEP);
    assign w_jit    = (r_mode == MODE_JITTER);
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_EMIT) && (!r_o_valid || !i_stall);
    assign w_last   = (r_led == LAST_LED);

    assign w_req.start   = (r_state == S_MUL);
    assign w_req.num     = n_prod[PROD_W-1:FRAC_W];

    // jitter range is two LEDs, so its whole part is bit 0 of the product's integer part
    assign w_range = w_sweep ? SWEEP_RANGE : JIT_RANGE;
    assign w_pos   = w_sweep ? 24'(r_sweep_pos) : 24'(r_jit_pos);
    assign w_step  = w_sweep ? 24'({w_rsp.rem, r_prod[FRAC_W-1:0]}) : 24'(r_prod[FRAC_W:0]);
    assign w_sum   = r_neg ? (w_pos + w_range - w_step) : (w_pos + w_step);
    assign w_new   = (w_sum >= w_range) ? (w_sum - w_range) : w_sum;

    assign w_diff  = {1'b0, r_led} - {1'b0, r_sweep_pos[POS_W-1:FRAC_W]};
    assign w_off   = w_diff[6] ? (w_diff + COUNT_7) : w_diff;
    assign w_bnext = {1'b0, r_bcnt} + 9'd1;

    always_comb begin
        w_fg = 1'b0;
        if (w_sweep) begin
            w_fg = ({1'b0, w_off} < r_block);
        end else if (w_jit) begin
            w_fg = (r_block != 8'd0) && (r_qpar ^ r_jit_pos[FRAC_W]);
        end
        if (w_sweep || w_jit) begin
            w_rgb = w_fg ? r_fore : r_back;
        end else begin
            w_rgb = r_solid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_prior     = r_prior;
        n_sweep_pos = r_sweep_pos;
        n_jit_pos   = r_jit_pos;
        n_now       = r_now;
        n_elapsed   = r_elapsed;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_led       = r_led;
        n_bcnt      = r_bcnt;
        n_qpar      = r_qpar;
        n_o_valid   = r_o_valid;
        n_o_idx     = r_o_idx;
        n_o_rgb     = r_o_rgb;
        n_o_end     = r_o_end;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_now     = i_now_ms;
                    n_elapsed = i_now_ms - r_prior;
                    n_neg     = r_rate[RATE_W-1];
                    n_mag     = r_rate[RATE_W-1] ? (~r_rate + 1'b1) : r_rate;
                    n_led     = '0;
                    n_bcnt    = '0;
                    n_qpar    = 1'b0;
                    n_state   = (w_sweep || w_jit) ? S_MUL : S_EMIT;
                end
            end
            S_MUL: begin
                n_prod  = r_mag * r_elapsed;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (w_rsp.done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_prior = r_now;
                if (w_sweep) begin
                    n_sweep_pos = w_new[POS_W-1:0];
                end else begin
                    n_jit_pos = w_new[JPOS_W-1:0];
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_o_valid = 1'b1;
                    n_o_idx   = r_led;
                    n_o_rgb   = w_rgb;
                    n_o_end   = w_last;
                    n_led     = r_led + 1'b1;
                    if (w_bnext == {1'b0, r_block}) begin
                        n_bcnt = '0;
                        n_qpar = ~r_qpar;
                    end else begin
                        n_bcnt = w_bnext[7:0];
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SOLID;
            r_solid     <= '0;
            r_fore      <= '0;
            r_back      <= '0;
            r_block     <= 8'd1;
            r_rate      <= '0;
            r_state     <= S_IDLE;
            r_prior     <= '0;
            r_sweep_pos <= '0;
            r_jit_pos   <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                    CFG_SOLID: r_solid <= i_cfg_data[RGB_W-1:0];
                    CFG_FORE:  r_fore  <= i_cfg_data[RGB_W-1:0];
                    CFG_BACK:  r_back  <= i_cfg_data[RGB_W-1:0];
                    CFG_BLOCK: r_block <= i_cfg_data[7:0];
                    CFG_RATE:  r_rate  <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            r_state     <= n_state;
            r_prior     <= n_prior;
            r_sweep_pos <= n_sweep_pos;
            r_jit_pos   <= n_jit_pos;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_elapsed <= n_elapsed;
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_prod    <= n_prod;
        r_led     <= n_led;
        r_bcnt    <= n_bcnt;
        r_qpar    <= n_qpar;
        r_o_idx   <= n_o_idx;
        r_o_rgb   <= n_o_rgb;
        r_o_end   <= n_o_end;
    end

    assign o_valid     = r_o_valid;
    assign o_led_index = r_o_idx;
    assign o_red       = r_o_rgb[23:16];
    assign o_green     = r_o_rgb[15:8];
    assign o_blue      = r_o_rgb[7:0];
    assign o_frame_end = r_o_end;

endmodule

// ===== rtl/lspg_modred.sv =====
// Remainder unit: reduces a wide value modulo a constant by two folds, a reciprocal multiply and a correction.
module lspg_modred import lspg_pkg::*; #(
    parameter int MODULUS = LED_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_red_req i_req,
    output t_red_rsp o_rsp
);

    localparam int SPLIT  = 20;
    localparam int FOLD_W = SPLIT + REM_W;
    localparam int SUM_W  = FOLD_W + 1;
    localparam int V_W    = SPLIT + 1;
    localparam int SH     = V_W + REM_W;
    localparam int RCP_W  = SH + 1;
    localparam int QP_W   = V_W + RCP_W;

    localparam logic [REM_W-1:0] FOLD_K = REM_W'((2 ** SPLIT) % MODULUS);
    localparam logic [RCP_W-1:0] RECIP  = RCP_W'(((2 ** SH) + MODULUS - 1) / MODULUS);
    localparam logic [MOD_W-1:0] MOD_C  = MOD_W'(MODULUS);

    t_red_phase        r_phase;
    logic              r_done;
    logic [NUM_W-1:0]  r_x;
    logic [V_W-1:0]    r_q;
    logic [REM_W-1:0]  r_rem;
    logic [FOLD_W-1:0] w_hi;
    logic [SUM_W-1:0]  w_fold;
    logic [QP_W-1:0]   w_qp;
    logic [V_W-1:0]    w_qm;
    logic [V_W-1:0]    w_diff;

    // x mod M == (x_hi * (2^SPLIT mod M) + x_lo) mod M
    assign w_hi   = FOLD_W'(r_x[NUM_W-1:SPLIT]) * FOLD_W'(FOLD_K);
    assign w_fold = SUM_W'(w_hi) + SUM_W'(r_x[SPLIT-1:0]);
    assign w_qp   = QP_W'(r_x[V_W-1:0]) * QP_W'(RECIP);
    assign w_qm   = r_q * V_W'(MOD_C);
    assign w_diff = r_x[V_W-1:0] - w_qm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                RP_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= RP_FOLD_A;
                    end
                end
                RP_FOLD_A: begin
                    r_phase <= RP_FOLD_B;
                end
                RP_FOLD_B: begin
                    r_phase <= RP_RECIP;
                end
                RP_RECIP: begin
                    r_phase <= RP_FIX;
                end
                RP_FIX: begin
                    r_done  <= 1'b1;
                    r_phase <= RP_IDLE;
                end
                default: begin
                    r_phase <= RP_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            RP_IDLE: begin
                if (i_req.start) begin
                    r_x <= i_req.num;
                end
            end
            RP_FOLD_A, RP_FOLD_B: begin
                r_x <= NUM_W'(w_fold);
            end
            RP_RECIP: begin
                r_q <= w_qp[SH +: V_W];
            end
            RP_FIX: begin
                r_rem <= w_diff[REM_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule
